// File: design/bdq_pkg.sv
// bdq_pkg: shared types and constants for the bounded deque with search
// no dependencies; used by the interfaces, the controller and the top level
`default_nettype none

package bdq_pkg;

    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    // request opcodes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_BACK   = 3'd2,
        FN_POP_FRONT  = 3'd3,
        FN_READ       = 3'd4,
        FN_SEARCH     = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_OUT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               found;
        logic [FILL_W-1:0]  fill;
        status_t            status;
    } res_t;

endpackage

`default_nettype wire

// File: design/bdq_if.sv
// bdq_req_if and bdq_rsp_if: valid/ready channels for requests and results
// depends on bdq_pkg for field widths
`default_nettype none

interface bdq_req_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::FUNC_W-1:0]    func;
    logic [bdq_pkg::VALUE_W-1:0]   value;
    logic [bdq_pkg::POS_W-1:0]     position;

    modport source (output valid, output func, output value, output position, input ready);
    modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface bdq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::VALUE_W-1:0]   read_value;
    logic                          found;
    logic [bdq_pkg::FILL_W-1:0]    fill;
    logic [bdq_pkg::STATUS_W-1:0]  status;

    modport source (output valid, output read_value, output found, output fill,
                    output status, input ready);
    modport sink   (input valid, input read_value, input found, input fill,
                    input status, output ready);
endinterface

`default_nettype wire

// File: design/bdq_mem.sv
// bdq_mem: ring store, one write port and one read port with registered read data
// no package dependency
`default_nettype none

module bdq_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [DATA_WIDTH-1:0]        wdata,
    input  wire logic                         re,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic      [DATA_WIDTH-1:0]        rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/bdq_ctrl.sv
// bdq_ctrl: request sequencer, head and occupancy registers, search scan
// depends on bdq_pkg and bdq_req_if; drives the ports of bdq_mem
`default_nettype none

module bdq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    bdq_req_if.sink                           req,
    output bdq_pkg::res_t                     res,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic                              mem_we,
    output logic      [$clog2(DEPTH)-1:0]     mem_waddr,
    output logic      [DATA_WIDTH-1:0]        mem_wdata,
    output logic                              mem_re,
    output logic      [$clog2(DEPTH)-1:0]     mem_raddr,
    input  wire logic [DATA_WIDTH-1:0]        mem_rdata
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;

    bdq_pkg::state_t       state_reg, state_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         occ_reg, occ_next;
    logic [AW-1:0]         scan_reg, scan_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    bdq_pkg::res_t         res_reg, res_next;

    logic [DATA_WIDTH-1:0] wdata;
    logic                  full;
    logic                  empty;

    // base plus offset, wrapped once; offset is always below DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign wdata = DATA_WIDTH'(req.value);
    assign full  = (occ_reg == CW'(DEPTH));
    assign empty = (occ_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        occ_next   = occ_reg;
        scan_next  = scan_reg;
        key_next   = key_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_reg;
        mem_wdata  = wdata;
        mem_re     = 1'b0;
        mem_raddr  = head_reg;
        req.ready  = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            bdq_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    res_next.read_value = '0;
                    res_next.found      = 1'b0;
                    res_next.status     = bdq_pkg::ST_OK;
                    state_next          = bdq_pkg::S_DONE;
                    case (bdq_pkg::func_t'(req.func))
                        bdq_pkg::FN_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_next.status = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ring_add(head_reg, occ_reg);
                                occ_next  = occ_reg + CW'(1);
                            end
                        end
                        bdq_pkg::FN_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_next.status = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                head_next = (head_reg == '0) ? AW'(DEPTH - 1)
                                                             : head_reg - AW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = head_next;
                                occ_next  = occ_reg + CW'(1);
                            end
                        end
                        bdq_pkg::FN_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_next.status = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                occ_next = occ_reg - CW'(1);
                            end
                        end
                        bdq_pkg::FN_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_next.status = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next = ring_add(head_reg, CW'(1));
                                occ_next  = occ_reg - CW'(1);
                            end
                        end
                        bdq_pkg::FN_READ:
                        begin
                            if (CMPW'(req.position) >= CMPW'(occ_reg))
                            begin
                                res_next.status = bdq_pkg::ST_OUT_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ring_add(head_reg, CW'(req.position));
                                state_next = bdq_pkg::S_READ;
                            end
                        end
                        bdq_pkg::FN_SEARCH:
                        begin
                            key_next = wdata;
                            if (!empty)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = head_reg;
                                scan_next  = '0;
                                state_next = bdq_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.fill = bdq_pkg::FILL_W'(occ_next);
                end
            end
            bdq_pkg::S_READ:
            begin
                res_next.read_value = bdq_pkg::VALUE_W'(mem_rdata);
                state_next          = bdq_pkg::S_DONE;
            end
            bdq_pkg::S_SCAN:
            begin
                // read data belongs to the entry at scan_reg
                if (mem_rdata == key_reg)
                begin
                    res_next.found = 1'b1;
                    state_next     = bdq_pkg::S_DONE;
                end
                else if ((CW'(scan_reg) + CW'(1)) == occ_reg)
                begin
                    state_next = bdq_pkg::S_DONE;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = ring_add(head_reg, CW'(scan_reg) + CW'(1));
                end
            end
            bdq_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = bdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::S_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: design/bounded_deque_with_search.sv
// sequence: push, pop, bad read and empty search go from idle straight to done; a read passes
// through the read state; a search passes through the scan state, comparing n entries (at most
// the fill level), one entry per cycle through the single read port of the ring store
// a new request is taken once the previous result is in the output register
// reset: rst_n (async, active low) empties the queue; the store itself is not cleared
`default_nettype none

module bounded_deque_with_search #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_req_if.sink   req,
    bdq_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);

    // controller to output stage
    bdq_pkg::res_t         res;
    logic                  res_valid;
    logic                  res_ready;

    // ring store port signals
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // output register parting the result side from the sequencer
    logic                  rsp_valid_reg, rsp_valid_next;
    bdq_pkg::res_t         rsp_data_reg, rsp_data_next;

    bdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bdq_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output slot is free when empty or being drained this cycle
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_data_reg.read_value;
    assign rsp.found      = rsp_data_reg.found;
    assign rsp.fill       = rsp_data_reg.fill;
    assign rsp.status     = rsp_data_reg.status;

endmodule

`default_nettype wire

// File: sim/bdq_checker.sv
// bdq_checker: watches both deque channels, predicts every result and compares it
// depends on bdq_pkg and the request/result interfaces in bdq_if.sv
module bdq_checker #(
    parameter int DEPTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_req_if        req,
    bdq_rsp_if        rsp,
    output int        mismatches,
    output int        pending,
    output int        checked,
    output int        full_pushes,
    output int        empty_pops,
    output int        bad_reads,
    output int        search_hits
);
    import bdq_pkg::*;

    // own copy of the ring store
    logic [VALUE_W-1:0] ring [DEPTH];
    int unsigned        front;
    int unsigned        stored;

    res_t               answers [$];

    function automatic int unsigned slot_at(input int unsigned offset);
        return (front + offset) % DEPTH;
    endfunction

    // applies one request to the shadow deque and returns the answer it should give
    function automatic res_t deque_apply(input logic [FUNC_W-1:0]  op,
                                         input logic [VALUE_W-1:0] val,
                                         input logic [POS_W-1:0]   pos);
        res_t r;
        r = '0;
        r.status = ST_OK;
        case (op)
            FN_PUSH_BACK:
                if (stored >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    ring[slot_at(stored)] = val;
                    stored++;
                end
            FN_PUSH_FRONT:
                if (stored >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    front = slot_at(DEPTH - 1);
                    ring[front] = val;
                    stored++;
                end
            FN_POP_BACK:
                if (stored == 0)
                    r.status = ST_EMPTY;
                else
                    stored--;
            FN_POP_FRONT:
                if (stored == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    front = slot_at(1);
                    stored--;
                end
            FN_READ:
                if (pos >= stored)
                    r.status = ST_OUT_RANGE;
                else
                    r.read_value = ring[slot_at(pos)];
            FN_SEARCH:
                for (int unsigned i = 0; i < stored && !r.found; i++)
                    if (ring[slot_at(i)] == val)
                        r.found = 1'b1;
            default:
                ;
        endcase
        r.fill = FILL_W'(stored);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        res_t got;
        if (!rst_n)
        begin
            answers.delete();
            front       = 0;
            stored      = 0;
            mismatches  <= 0;
            pending     <= 0;
            checked     <= 0;
            full_pushes <= 0;
            empty_pops  <= 0;
            bad_reads   <= 0;
            search_hits <= 0;
        end
        else
        begin
            // results first: a request taken at this edge cannot answer at the same edge
            if (rsp.valid && rsp.ready)
            begin
                got.read_value = rsp.read_value;
                got.found      = rsp.found;
                got.fill       = rsp.fill;
                got.status     = status_t'(rsp.status);
                if (answers.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unrequested result: %h/%b/%0d/%0d",
                                 got.read_value, got.found, got.fill, got.status);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = answers.pop_front();
                    if (got.read_value !== want.read_value || got.found !== want.found ||
                        got.fill !== want.fill || got.status !== want.status)
                    begin
                        if (mismatches < 10)
                            $display("result %0d: want %h/%b/%0d/%0d got %h/%b/%0d/%0d",
                                     checked, want.read_value, want.found, want.fill,
                                     want.status, got.read_value, got.found, got.fill,
                                     got.status);
                        mismatches <= mismatches + 1;
                    end
                    checked     <= checked + 1;
                    full_pushes <= full_pushes + (want.status == ST_FULL);
                    empty_pops  <= empty_pops + (want.status == ST_EMPTY);
                    bad_reads   <= bad_reads + (want.status == ST_OUT_RANGE);
                    search_hits <= search_hits + want.found;
                end
            end
            if (req.valid && req.ready)
                answers.push_back(deque_apply(req.func, req.value, req.position));
            pending <= answers.size();
        end
    end

endmodule

// File: sim/testbench.sv
// testbench: request stimulus, result back-pressure and verdict for the bounded deque
// depends on bdq_pkg, bdq_if.sv, the deque rtl and bdq_checker
module testbench;
    import bdq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1550;
    // longest answer is a full search, which compares every stored entry
    localparam int DRAIN_CYCLES = 2 + DEPTH + 8;

    // request mixes that steer the fill level up, down, or let it wander
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_CHURN
    } mix_t;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;               // high while neither side idles
    int   issued = 0;

    int   mismatches;
    int   pending;
    int   checked;
    int   full_pushes;
    int   empty_pops;
    int   bad_reads;
    int   search_hits;

    // a few recurring values so that searches hit as well as miss
    logic [VALUE_W-1:0] pool [8];

    bdq_req_if req_ch ();
    bdq_rsp_if rsp_ch ();

    bounded_deque_with_search #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bdq_checker #(
        .DEPTH (DEPTH)
    ) watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .full_pushes (full_pushes),
        .empty_pops  (empty_pops),
        .bad_reads   (bad_reads),
        .search_hits (search_hits)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: ready is dropped with a chance of 38 in 100, never while steady
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= rst_n && (steady || $urandom_range(99) >= 38);
        end
    end

    // one request: optional idle gap, then hold it until the deque takes it
    // valid is only lowered when a gap follows, so back-to-back requests keep it high
    task automatic issue(input func_t op, input logic [VALUE_W-1:0] val,
                         input logic [POS_W-1:0] pos);
        if (!steady)
            while ($urandom_range(99) < 38)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= op;
        req_ch.value    <= val;
        req_ch.position <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        issued++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return pool[$urandom_range(7)];
        return $urandom();
    endfunction

    // operation choice biased by the current mix
    function automatic func_t choose_op(input mix_t mix);
        int push_lim;
        int pop_lim;
        int read_lim;
        int roll;
        case (mix)
            MIX_GROW:
            begin
                push_lim = 60; pop_lim = 68; read_lim = 85;
            end
            MIX_SHRINK:
            begin
                push_lim = 15; pop_lim = 65; read_lim = 82;
            end
            default:
            begin
                push_lim = 30; pop_lim = 55; read_lim = 78;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < push_lim)
            return $urandom_range(1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
        if (roll < pop_lim)
            return $urandom_range(1) ? FN_POP_FRONT : FN_POP_BACK;
        if (roll < read_lim)
            return FN_READ;
        return FN_SEARCH;
    endfunction

    initial
    begin : stimulus
        mix_t mix;
        int   mix_left;
        mix      = MIX_CHURN;
        mix_left = 0;

        rst_n           <= 1'b0;
        steady          <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FN_PUSH_BACK;
        req_ch.value    <= '0;
        req_ch.position <= '0;

        pool[0] = '0;
        pool[1] = '1;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h0000_0001;
        for (int i = 4; i < 8; i++)
            pool[i] = $urandom();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty deque: search miss, underflow at both ends, read out of range
        issue(FN_SEARCH, '0, '0);
        issue(FN_POP_BACK, '0, '0);
        issue(FN_POP_FRONT, '1, '1);
        issue(FN_READ, '0, '0);
        // push front onto an empty deque wraps the head round the ring
        issue(FN_PUSH_FRONT, '1, '0);
        issue(FN_PUSH_BACK, '0, '1);
        issue(FN_PUSH_FRONT, 32'h0000_0001, '0);
        issue(FN_PUSH_BACK, 32'hA5A5_5A5A, '0);
        issue(FN_READ, '0, 4'd0);
        issue(FN_READ, '1, 4'd1);
        issue(FN_READ, '0, 4'd2);
        issue(FN_READ, '0, 4'd3);
        // position equal to the fill level and the largest position
        issue(FN_READ, '0, 4'd4);
        issue(FN_READ, '0, 4'd15);
        issue(FN_SEARCH, '1, '0);
        issue(FN_SEARCH, '0, '0);
        issue(FN_SEARCH, 32'h5A5A_A5A5, '0);
        issue(FN_POP_BACK, '0, '0);
        issue(FN_POP_FRONT, '0, '0);
        issue(FN_READ, '0, 4'd0);
        // popped values must no longer be found
        issue(FN_SEARCH, 32'hA5A5_5A5A, '0);
        issue(FN_POP_BACK, '0, '0);
        issue(FN_POP_FRONT, '0, '0);
        issue(FN_POP_FRONT, '0, '0);

        // random part: mixes alternate so the deque runs full and empty again and again
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mix_left == 0)
            begin
                mix      = mix_t'($urandom_range(2));
                mix_left = $urandom_range(20, 60);
            end
            mix_left--;
            steady <= (n >= 700 && n < 1000);
            issue(choose_op(mix), pick_value(), POS_W'($urandom_range(DEPTH - 1)));
        end
        req_ch.valid <= 1'b0;

        // the outstanding count is registered, so step past a clock edge before looking at it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 issued, checked, mismatches);
        $display("covered %0d refused pushes, %0d empty pops, %0d bad reads, %0d search hits",
                 full_pushes, empty_pops, bad_reads, search_hits);
        if (mismatches == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: bounded_deque_with_search.f
design/bdq_pkg.sv
design/bdq_if.sv
design/bdq_mem.sv
design/bdq_ctrl.sv
design/bounded_deque_with_search.sv
sim/bdq_checker.sv
sim/testbench.sv
